// ----- hw/rtl/pcomp_pkg.sv -----
package pcomp_pkg;

    // Default widths of the sample path and the ratio fraction
    localparam int SAMPLE_BITS_DEF     = 24;
    localparam int RATIO_FRAC_BITS_DEF = 16;

    // Configuration register indexes
    localparam int CFG_INDEX_BITS = 2;
    localparam logic [CFG_INDEX_BITS-1:0] REG_THRESHOLD_LEVEL = 2'd0;
    localparam logic [CFG_INDEX_BITS-1:0] REG_INVERSE_RATIO   = 2'd1;

    // Threshold after reset, in sample units
    localparam int THRESHOLD_RESET = 8389;

    // How the gain stage treats one item
    typedef struct packed {
        logic compress;   // level is above threshold: scale the excess
        logic pos;        // sample is positive: reference is +threshold
    } pcomp_mode_t;

endpackage

// ----- hw/rtl/peak_tracking_audio_compressor.sv -----
// Peak-tracking audio compressor.
// Input stream s_*: one signed sample per item in the low bits of s_tdata.
// Output stream m_*: one compressed sample per input item, in order.
// Config channel cfg_*: index 0 writes threshold_level, index 1 writes
// inverse_ratio (Q1.RATIO_FRAC_BITS); other indexes are ignored. cfg_ready
// is always high; write only while no item is in flight.
// A sample passes the input register, the tracking/operand register and the
// result register in that order before its result shows on m_tvalid.
// Throughput: one item per cycle unless m_tready stalls; the level tracker
// updates per item and the single multiply sits in its own stage.
// Reset clears the level tracker and all valid flags and loads the default
// threshold and a ratio of one half.
// When m_tready is low the result register holds; the stages behind it keep
// filling until each holds an item, then s_tready drops.
module peak_tracking_audio_compressor #(
    parameter int SAMPLE_BITS     = pcomp_pkg::SAMPLE_BITS_DEF,
    parameter int RATIO_FRAC_BITS = pcomp_pkg::RATIO_FRAC_BITS_DEF,
    localparam int DATA_BITS = ((SAMPLE_BITS + 7) / 8) * 8,
    localparam int CFG_BITS  = (SAMPLE_BITS - 1 > RATIO_FRAC_BITS + 1) ?
                               (SAMPLE_BITS - 1) : (RATIO_FRAC_BITS + 1)
) (
    input  logic                                 clk,
    input  logic                                 rst_n,
    input  logic                                 s_tvalid,
    output logic                                 s_tready,
    input  logic [DATA_BITS-1:0]                 s_tdata,   // sample_in
    output logic                                 m_tvalid,
    input  logic                                 m_tready,
    output logic [DATA_BITS-1:0]                 m_tdata,   // sample_out
    input  logic                                 cfg_valid,
    output logic                                 cfg_ready,
    input  logic [pcomp_pkg::CFG_INDEX_BITS-1:0] cfg_index,
    input  logic [CFG_BITS-1:0]                  cfg_data
);

    localparam int W = SAMPLE_BITS;
    localparam int F = RATIO_FRAC_BITS;

    localparam logic [W-2:0] THRESHOLD_INIT = (W-1)'(pcomp_pkg::THRESHOLD_RESET);
    localparam logic [F:0]   RATIO_INIT     = (F+1)'(1) << (F - 1);

    logic [W-2:0] threshold_reg;
    logic [F:0]   ratio_reg;

    logic                v1_reg, v2_reg, v3_reg;
    logic                adv1, adv2, adv3;
    logic signed [W-1:0] in_sample_reg;

    logic signed [W-1:0]    op_sample;
    logic signed [W-1:0]    op_excess;
    pcomp_pkg::pcomp_mode_t op_mode;
    logic signed [W-1:0]    result;

    // Take configuration writes at any time
    assign cfg_ready = 1'b1;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            threshold_reg <= THRESHOLD_INIT;
            ratio_reg     <= RATIO_INIT;
        end
        else if (cfg_valid)
        begin
            unique case (cfg_index)
                pcomp_pkg::REG_THRESHOLD_LEVEL: threshold_reg <= cfg_data[W-2:0];
                pcomp_pkg::REG_INVERSE_RATIO:   ratio_reg     <= cfg_data[F:0];
                default:                        ;
            endcase
        end
    end

    // Each stage moves on when the next one is empty or moving
    assign adv3     = !v3_reg || m_tready;
    assign adv2     = !v2_reg || adv3;
    assign adv1     = !v1_reg || adv2;
    assign s_tready = adv1;
    assign m_tvalid = v3_reg;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            v1_reg <= 1'b0;
            v2_reg <= 1'b0;
            v3_reg <= 1'b0;
        end
        else
        begin
            if (adv1)
            begin
                v1_reg <= s_tvalid;
            end
            if (adv2)
            begin
                v2_reg <= v1_reg;
            end
            if (adv3)
            begin
                v3_reg <= v2_reg;
            end
        end
    end

    // Capture the incoming sample
    always_ff @(posedge clk)
    begin
        if (s_tvalid && adv1)
        begin
            in_sample_reg <= s_tdata[W-1:0];
        end
    end

    pcomp_tracker #(
        .SAMPLE_BITS (W)
    ) u_tracker (
        .clk       (clk),
        .rst_n     (rst_n),
        .load      (v1_reg && adv2),
        .sample    (in_sample_reg),
        .threshold (threshold_reg),
        .op_sample (op_sample),
        .op_excess (op_excess),
        .op_mode   (op_mode)
    );

    pcomp_gain #(
        .SAMPLE_BITS     (W),
        .RATIO_FRAC_BITS (F)
    ) u_gain (
        .clk           (clk),
        .load          (v2_reg && adv3),
        .op_sample     (op_sample),
        .op_excess     (op_excess),
        .op_mode       (op_mode),
        .threshold     (threshold_reg),
        .inverse_ratio (ratio_reg),
        .result        (result)
    );

    // Pad the result with zeros to whole bytes
    assign m_tdata = DATA_BITS'($unsigned(result));

endmodule

// ----- hw/rtl/pcomp_tracker.sv -----
module pcomp_tracker #(
    parameter int SAMPLE_BITS = pcomp_pkg::SAMPLE_BITS_DEF
) (
    input  logic                          clk,
    input  logic                          rst_n,
    input  logic                          load,
    input  logic signed [SAMPLE_BITS-1:0] sample,
    input  logic        [SAMPLE_BITS-2:0] threshold,
    output logic signed [SAMPLE_BITS-1:0] op_sample,
    output logic signed [SAMPLE_BITS-1:0] op_excess,
    output pcomp_pkg::pcomp_mode_t        op_mode
);

    localparam int W = SAMPLE_BITS;

    // Tracking state; only the sign of each slope is ever needed
    logic signed [W:0]   level_reg, level_next;
    logic                cur_neg_reg, cur_neg_next;
    logic                prev_neg_reg;
    logic signed [W-1:0] prev_sample_reg;

    // Operand register toward the gain stage
    logic signed [W-1:0]   op_sample_reg;
    logic signed [W-1:0]   op_excess_reg, op_excess_next;
    pcomp_pkg::pcomp_mode_t op_mode_reg, op_mode_next;

    logic signed [W:0] x_ext;
    logic signed [W:0] mag;
    logic signed [W:0] slope;
    logic signed [W:0] thr_ext;
    logic signed [W:0] excess_wide;
    logic              slope_neg;

    // Form magnitude and slope sign
    always_comb
    begin
        x_ext     = {sample[W-1], sample};
        mag       = x_ext[W] ? -x_ext : x_ext;
        slope     = x_ext - {prev_sample_reg[W-1], prev_sample_reg};
        slope_neg = slope[W];
        thr_ext   = {2'b00, threshold};
    end

    // Update the level: raise on a larger magnitude, reset at a turning point
    always_comb
    begin
        level_next   = level_reg;
        cur_neg_next = cur_neg_reg;
        if (mag > level_reg)
        begin
            level_next = mag;
        end
        else
        begin
            cur_neg_next = slope_neg;
            if (!slope_neg && prev_neg_reg)
            begin
                level_next = -x_ext;
            end
            else if (slope_neg && !prev_neg_reg)
            begin
                level_next = x_ext;
            end
        end
    end

    // Pick the reference and form the excess beyond it
    always_comb
    begin
        op_mode_next.compress = (level_next > thr_ext);
        op_mode_next.pos      = !sample[W-1] && (sample != '0);
        excess_wide           = op_mode_next.pos ? (x_ext - thr_ext) : (x_ext + thr_ext);
        op_excess_next        = excess_wide[W-1:0];
    end

    // Advance the tracking state as each item moves on
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            level_reg       <= '0;
            cur_neg_reg     <= 1'b0;
            prev_neg_reg    <= 1'b0;
            prev_sample_reg <= '0;
        end
        else if (load)
        begin
            level_reg       <= level_next;
            cur_neg_reg     <= cur_neg_next;
            prev_neg_reg    <= cur_neg_next;
            prev_sample_reg <= sample;
        end
    end

    // Hold the operands for the gain stage
    always_ff @(posedge clk)
    begin
        if (load)
        begin
            op_sample_reg <= sample;
            op_excess_reg <= op_excess_next;
            op_mode_reg   <= op_mode_next;
        end
    end

    assign op_sample = op_sample_reg;
    assign op_excess = op_excess_reg;
    assign op_mode   = op_mode_reg;

endmodule

// ----- hw/rtl/pcomp_gain.sv -----
module pcomp_gain #(
    parameter int SAMPLE_BITS     = pcomp_pkg::SAMPLE_BITS_DEF,
    parameter int RATIO_FRAC_BITS = pcomp_pkg::RATIO_FRAC_BITS_DEF
) (
    input  logic                          clk,
    input  logic                          load,
    input  logic signed [SAMPLE_BITS-1:0] op_sample,
    input  logic signed [SAMPLE_BITS-1:0] op_excess,
    input  pcomp_pkg::pcomp_mode_t        op_mode,
    input  logic        [SAMPLE_BITS-2:0] threshold,
    input  logic        [RATIO_FRAC_BITS:0] inverse_ratio,
    output logic signed [SAMPLE_BITS-1:0] result
);

    localparam int W = SAMPLE_BITS;
    localparam int F = RATIO_FRAC_BITS;

    localparam logic signed [W+1:0] MAX_OUT = (W+2)'((64'd1 << (W - 1)) - 64'd1);
    localparam logic signed [W+1:0] MIN_OUT = -MAX_OUT - (W+2)'(1);

    logic signed [F+1:0]   ratio_s;
    logic signed [W+F+1:0] product;
    logic signed [W+1:0]   scaled;
    logic signed [W+1:0]   thr_ext;
    logic signed [W+1:0]   sum;
    logic signed [W-1:0]   result_reg, result_next;

    // Scale the excess, shift down, add the reference back, saturate; else pass the sample
    always_comb
    begin
        ratio_s = $signed({1'b0, inverse_ratio});
        product = (W+F+2)'(op_excess) * (W+F+2)'(ratio_s);
        scaled  = product[W+F+1:F];
        thr_ext = {3'b000, threshold};
        sum     = op_mode.pos ? (scaled + thr_ext) : (scaled - thr_ext);
        if (!op_mode.compress)
        begin
            result_next = op_sample;
        end
        else if (sum > MAX_OUT)
        begin
            result_next = MAX_OUT[W-1:0];
        end
        else if (sum < MIN_OUT)
        begin
            result_next = MIN_OUT[W-1:0];
        end
        else
        begin
            result_next = sum[W-1:0];
        end
    end

    // Hold the result until the receiver takes it
    always_ff @(posedge clk)
    begin
        if (load)
        begin
            result_reg <= result_next;
        end
    end

    assign result = result_reg;

endmodule

// ----- test/peak_tracking_audio_compressor_checker.sv -----
`timescale 1ns / 100ps

module peak_tracking_audio_compressor_checker #(
    parameter int SAMPLE_BITS     = pcomp_pkg::SAMPLE_BITS_DEF,
    parameter int RATIO_FRAC_BITS = pcomp_pkg::RATIO_FRAC_BITS_DEF,
    parameter int DATA_BITS       = ((SAMPLE_BITS + 7) / 8) * 8,
    parameter int CFG_BITS        = (SAMPLE_BITS - 1 > RATIO_FRAC_BITS + 1) ?
                                    (SAMPLE_BITS - 1) : (RATIO_FRAC_BITS + 1)
) (
    input  logic                                 clk,
    input  logic                                 rst_n,
    input  logic                                 s_tvalid,
    input  logic                                 s_tready,
    input  logic [DATA_BITS-1:0]                 s_tdata,   // sample_in
    input  logic                                 m_tvalid,
    input  logic                                 m_tready,
    input  logic [DATA_BITS-1:0]                 m_tdata,   // sample_out
    input  logic                                 cfg_valid,
    input  logic                                 cfg_ready,
    input  logic [pcomp_pkg::CFG_INDEX_BITS-1:0] cfg_index,
    input  logic [CFG_BITS-1:0]                  cfg_data,
    output int                                   errors,
    output int                                   pending
);
    import pcomp_pkg::*;

    // Register copies
    logic [SAMPLE_BITS-2:0]     thresh;
    logic [RATIO_FRAC_BITS:0]   inv_ratio;

    // Level tracker copies
    logic signed [SAMPLE_BITS:0]   level_est;
    logic signed [SAMPLE_BITS+1:0] slope_now;
    logic signed [SAMPLE_BITS+1:0] slope_last;
    logic signed [SAMPLE_BITS-1:0] last_sample;

    // Compressed samples still owed by the block, oldest first
    logic [SAMPLE_BITS-1:0] owed_out [$];
    logic [SAMPLE_BITS-1:0] want_out;

    task automatic report_mismatch(input string what);
        $display("mismatch at %0t ns: %s", $time, what);
        errors++;
    endtask

    // Track the level, then scale the excess beyond the threshold
    function automatic logic [SAMPLE_BITS-1:0] compress_sample(
        input logic signed [SAMPLE_BITS-1:0] x
    );
        logic signed [SAMPLE_BITS:0] xw;
        logic signed [SAMPLE_BITS:0] mag;
        longint t;
        longint r;
        longint y;
        longint top_val;
        xw  = (SAMPLE_BITS+1)'(x);
        mag = (xw < 0) ? -xw : xw;
        if (mag > level_est)
            level_est = mag;
        else
        begin
            slope_now = (SAMPLE_BITS+2)'(x) - (SAMPLE_BITS+2)'(last_sample);
            if (slope_now >= 0 && slope_last < 0)
                level_est = -xw;
            else if (slope_now < 0 && slope_last >= 0)
                level_est = xw;
        end
        slope_last  = slope_now;
        last_sample = x;

        t = longint'(thresh);
        r = longint'(inv_ratio);
        y = longint'(x);
        if (longint'(level_est) > t)
        begin
            if (x > 0)
                y = (((y - t) * r) >>> RATIO_FRAC_BITS) + t;
            else
                y = (((y + t) * r) >>> RATIO_FRAC_BITS) - t;
        end
        // clamp to the signed sample range
        top_val = (longint'(1) <<< (SAMPLE_BITS - 1)) - 1;
        if (y > top_val)
            y = top_val;
        else if (y < -top_val - 1)
            y = -top_val - 1;
        return y[SAMPLE_BITS-1:0];
    endfunction

    // Watch all three channels at each rising edge
    always @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            thresh      = (SAMPLE_BITS-1)'(THRESHOLD_RESET);
            inv_ratio   = (RATIO_FRAC_BITS+1)'(1) << (RATIO_FRAC_BITS - 1);
            level_est   = '0;
            slope_now   = '0;
            slope_last  = '0;
            last_sample = '0;
            owed_out.delete();
            errors      = 0;
            pending     = 0;
        end
        else
        begin
            // apply register writes, masked to register widths
            if (cfg_valid && cfg_ready)
            begin
                if (cfg_index == REG_THRESHOLD_LEVEL)
                    thresh = cfg_data[SAMPLE_BITS-2:0];
                else if (cfg_index == REG_INVERSE_RATIO)
                    inv_ratio = cfg_data[RATIO_FRAC_BITS:0];
            end

            if (s_tvalid && s_tready)
                owed_out.push_back(compress_sample(s_tdata[SAMPLE_BITS-1:0]));

            // compare each result with the oldest owed sample
            if (m_tvalid && m_tready)
            begin
                if (owed_out.size() == 0)
                    report_mismatch($sformatf("unexpected item %0d",
                                              $signed(m_tdata[SAMPLE_BITS-1:0])));
                else
                begin
                    want_out = owed_out.pop_front();
                    if (m_tdata[SAMPLE_BITS-1:0] !== want_out)
                        report_mismatch($sformatf("sample_out got %0d want %0d",
                                                  $signed(m_tdata[SAMPLE_BITS-1:0]),
                                                  $signed(want_out)));
                end
            end
            pending = owed_out.size();
        end
    end

endmodule

// ----- test/peak_tracking_audio_compressor_tb.sv -----
`timescale 1ns / 100ps

module peak_tracking_audio_compressor_tb;
    import pcomp_pkg::*;

    localparam int SMP_W  = SAMPLE_BITS_DEF;
    localparam int FRAC_W = RATIO_FRAC_BITS_DEF;
    localparam int DATA_W = ((SMP_W + 7) / 8) * 8;
    localparam int CFG_W  = (SMP_W - 1 > FRAC_W + 1) ? (SMP_W - 1) : (FRAC_W + 1);

    // Indexes that decode to no register
    localparam logic [CFG_INDEX_BITS-1:0] REG_SPARE_A = 2'd2;
    localparam logic [CFG_INDEX_BITS-1:0] REG_SPARE_B = 2'd3;

    localparam int SMP_MAX      = (1 << (SMP_W - 1)) - 1;
    localparam int THRESH_MAX   = (1 << (SMP_W - 1)) - 1;
    localparam int RATIO_ONE    = 1 << FRAC_W;
    localparam int RATIO_FULL   = (1 << (FRAC_W + 1)) - 1;
    localparam int RATIO_LOW    = 6554;
    localparam int RAND_PHASES  = 8;
    localparam int PHASE_ITEMS  = 235;
    localparam int HOLD_AT_ITEM = 400;
    localparam int HOLD_CYCLES  = 300;

    logic                      clk;
    logic                      rst_n     = 1'b0;
    logic                      s_tvalid  = 1'b0;
    logic                      s_tready;
    logic [DATA_W-1:0]         s_tdata   = '0;  // sample_in
    logic                      m_tvalid;
    logic                      m_tready  = 1'b0;
    logic [DATA_W-1:0]         m_tdata;         // sample_out
    logic                      cfg_valid = 1'b0;
    logic                      cfg_ready;
    logic [CFG_INDEX_BITS-1:0] cfg_index = '0;
    logic [CFG_W-1:0]          cfg_data  = '0;

    int  errors;
    int  pending;
    bit  long_hold = 1'b0;
    bit  send_steady = 1'b0;
    bit  recv_steady = 1'b0;
    int  send_count = 0;

    // Waveform generator state
    int  wave_pos  = 0;
    int  wave_amp  = 1;
    int  wave_step = 1;
    int  wave_dir  = 1;
    int  wave_left = 0;

    // Directed samples: extremes, level raise, peak, trough, threshold edges
    int  tour_default [15] = '{0, 8388607, -8388608, 1000, 2000, 1500, 300, 700,
                               20000, -20000, 8390, -8390, 1, -1, 4194304};
    int  tour_boost   [5]  = '{8388607, -8388608, 5000000, -5000000, 0};
    int  tour_flat    [4]  = '{-8388608, 8388607, -100, 100};

    peak_tracking_audio_compressor DUT (
        .clk       (clk),
        .rst_n     (rst_n),
        .s_tvalid  (s_tvalid),
        .s_tready  (s_tready),
        .s_tdata   (s_tdata),
        .m_tvalid  (m_tvalid),
        .m_tready  (m_tready),
        .m_tdata   (m_tdata),
        .cfg_valid (cfg_valid),
        .cfg_ready (cfg_ready),
        .cfg_index (cfg_index),
        .cfg_data  (cfg_data)
    );

    peak_tracking_audio_compressor_checker checker_i (
        .clk       (clk),
        .rst_n     (rst_n),
        .s_tvalid  (s_tvalid),
        .s_tready  (s_tready),
        .s_tdata   (s_tdata),
        .m_tvalid  (m_tvalid),
        .m_tready  (m_tready),
        .m_tdata   (m_tdata),
        .cfg_valid (cfg_valid),
        .cfg_ready (cfg_ready),
        .cfg_index (cfg_index),
        .cfg_data  (cfg_data),
        .errors    (errors),
        .pending   (pending)
    );

    initial
    begin
        clk = 1'b0;
        forever #4 clk = ~clk;
    end

    // Bound the run
    initial
    begin
        #4000000;
        $display("FAILURE");
        $finish;
    end

    // Offer one sample after a random gap; hold valid until accepted
    task automatic send_sample(input int v);
        int gap;
        if (send_count % 40 == 0)
            send_steady = ($urandom_range(0, 3) == 0);
        send_count++;
        gap = (send_steady || long_hold) ? 0 : $urandom_range(0, 11);
        if (gap > 0)
        begin
            s_tvalid <= 1'b0;
            repeat (gap) @(negedge clk);
        end
        s_tvalid <= 1'b1;
        s_tdata  <= DATA_W'(v);
        do
            @(posedge clk);
        while (!s_tready);
        @(negedge clk);
    endtask

    task automatic write_reg(input logic [CFG_INDEX_BITS-1:0] idx, input int val);
        cfg_valid <= 1'b1;
        cfg_index <= idx;
        cfg_data  <= CFG_W'(val);
        do
            @(posedge clk);
        while (!cfg_ready);
        @(negedge clk);
        cfg_valid <= 1'b0;
        @(negedge clk);
    endtask

    // Drop valid and wait until every owed result has come back
    task automatic drain_block();
        s_tvalid <= 1'b0;
        while (pending != 0)
            @(negedge clk);
        repeat (4) @(negedge clk);
    endtask

    // Mostly triangle waves with jitter, some full-range noise and extremes
    function automatic int next_audio();
        int pick;
        int v;
        int jitter;
        if (wave_left == 0)
        begin
            wave_amp  = $urandom_range(1, SMP_MAX) >> $urandom_range(0, 16);
            if (wave_amp == 0)
                wave_amp = 1;
            wave_step = wave_amp / $urandom_range(2, 48) + 1;
            wave_left = $urandom_range(16, 96);
            wave_dir  = $urandom_range(0, 1) ? 1 : -1;
        end
        wave_left--;
        pick = $urandom_range(0, 19);
        if (pick < 3)
            v = $urandom_range(0, 2 * SMP_MAX + 1) - (SMP_MAX + 1);
        else if (pick < 5)
        begin
            case ($urandom_range(0, 5))
                0: v = SMP_MAX;
                1: v = -SMP_MAX - 1;
                2: v = 0;
                3: v = 1;
                4: v = -1;
                default: v = -wave_amp;
            endcase
        end
        else
        begin
            jitter = $urandom_range(0, wave_step / 4);
            if ($urandom_range(0, 1))
                jitter = -jitter;
            wave_pos = wave_pos + wave_dir * wave_step + jitter;
            if (wave_pos >= wave_amp)
            begin
                wave_pos = wave_amp;
                wave_dir = -1;
            end
            else if (wave_pos <= -wave_amp)
            begin
                wave_pos = -wave_amp;
                wave_dir = 1;
            end
            v = wave_pos;
        end
        if (v > SMP_MAX)
            v = SMP_MAX;
        else if (v < -SMP_MAX - 1)
            v = -SMP_MAX - 1;
        return v;
    endfunction

    // Result side: random stalls, one long hold-off to back up the block
    initial
    begin
        int gap;
        int got;
        bit held;
        got  = 0;
        held = 1'b0;
        @(posedge rst_n);
        @(negedge clk);
        forever
        begin
            if (got % 50 == 0)
                recv_steady = ($urandom_range(0, 2) == 0);
            if (!held && got == HOLD_AT_ITEM)
            begin
                held      = 1'b1;
                long_hold = 1'b1;
                m_tready <= 1'b0;
                repeat (HOLD_CYCLES) @(negedge clk);
                long_hold = 1'b0;
            end
            else
            begin
                gap = recv_steady ? 0 : $urandom_range(0, 11);
                if (gap > 0)
                begin
                    m_tready <= 1'b0;
                    repeat (gap) @(negedge clk);
                end
            end
            m_tready <= 1'b1;
            do
                @(posedge clk);
            while (!m_tvalid);
            got++;
            @(negedge clk);
        end
    end

    // Stimulus and verdict
    initial
    begin
        int ph;
        int n;
        int t_val;
        int r_val;
        repeat (4) @(negedge clk);
        rst_n <= 1'b1;
        @(negedge clk);

        // register values after reset
        foreach (tour_default[i])
            send_sample(tour_default[i]);
        drain_block();

        // ratio above one with zero threshold: saturate both ways
        write_reg(REG_THRESHOLD_LEVEL, 0);
        write_reg(REG_INVERSE_RATIO, RATIO_FULL);
        foreach (tour_boost[i])
            send_sample(tour_boost[i]);
        drain_block();

        // ratio zero via masked high bits, top threshold, writes to spare indexes
        write_reg(REG_INVERSE_RATIO, int'({CFG_W{1'b1}}) & ~RATIO_FULL);
        write_reg(REG_THRESHOLD_LEVEL, THRESH_MAX);
        write_reg(REG_SPARE_A, $urandom_range(0, (1 << CFG_W) - 1));
        write_reg(REG_SPARE_B, $urandom_range(0, (1 << CFG_W) - 1));
        foreach (tour_flat[i])
            send_sample(tour_flat[i]);
        drain_block();

        // random phases, each under its own register setting
        for (ph = 0; ph < RAND_PHASES; ph++)
        begin
            case (ph)
                0:
                begin
                    t_val = 0;
                    r_val = RATIO_LOW;
                end
                1:
                begin
                    t_val = THRESH_MAX;
                    r_val = RATIO_ONE;
                end
                2:
                begin
                    t_val = THRESHOLD_RESET;
                    r_val = RATIO_ONE / 2;
                end
                default:
                begin
                    t_val = $urandom_range(0, THRESH_MAX) >> $urandom_range(0, 14);
                    r_val = $urandom_range(RATIO_LOW, RATIO_ONE);
                end
            endcase
            write_reg(REG_THRESHOLD_LEVEL, t_val);
            write_reg(REG_INVERSE_RATIO, r_val);
            for (n = 0; n < PHASE_ITEMS; n++)
                send_sample(next_audio());
            drain_block();
        end

        repeat (8) @(negedge clk);
        if (errors == 0)
            $display("SUCCESS");
        else
            $display("FAILURE");
        $finish;
    end

endmodule
